// ===== src/atpts_pkg.sv =====
package atpts_pkg;

    // Limits applied to the configured values
    localparam logic [15:0] POS_LIMIT  = 16'd32768;
    localparam logic [11:0] TIME_LIMIT = 12'd2500;
    localparam logic [12:0] HOLD_LIMIT = 13'd5000;

    localparam int unsigned CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEST_CODE       = 3'd0,
        CFG_FIRST_POSITION  = 3'd1,
        CFG_SECOND_POSITION = 3'd2,
        CFG_ON_TICKS        = 3'd3,
        CFG_OFF_TICKS       = 3'd4,
        CFG_HOLD_TICKS      = 3'd5
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POS1 = 4'b0010,
        ST_POS2 = 4'b0100,
        ST_END  = 4'b1000
    } t_state;

    // Phase codes as reported on the result stream
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_ONE  = 2'd1;
    localparam logic [1:0] PHASE_TWO  = 2'd2;
    localparam logic [1:0] PHASE_END  = 2'd3;

    function automatic logic [15:0] clamp_pos(input logic [15:0] v);
        return (v > POS_LIMIT) ? POS_LIMIT : v;
    endfunction

    function automatic logic [11:0] clamp_time(input logic [15:0] v);
        return (v > {4'd0, TIME_LIMIT}) ? TIME_LIMIT : v[11:0];
    endfunction

    function automatic logic [12:0] clamp_hold(input logic [15:0] v);
        return (v > {3'd0, HOLD_LIMIT}) ? HOLD_LIMIT : v[12:0];
    endfunction

endpackage

// ===== src/actuator_two_position_test_sequencer_core.sv =====
// Latency: a result is valid the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle; the single output register is refilled in the
// same cycle it is drained, so the input stalls only while a result is held.
// Reset (synchronous, active low) returns the sequencer to idle, clears all
// configuration registers to zero and empties the output register.
module actuator_two_position_test_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // tick stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [0] service_enable, [8:1] action_code, rest zero
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // [1:0] phase, [2] in_progress, [3] complete,
                                         // [19:4] position_request, rest zero
);

    // configuration, stored already clamped
    logic [7:0]  r_test_code;
    logic [15:0] r_first_pos;
    logic [15:0] r_second_pos;
    logic [11:0] r_on_ticks;
    logic [11:0] r_off_ticks;
    logic [12:0] r_hold_ticks;

    atpts_pkg::t_state r_state, n_state;
    logic [11:0] r_interval, n_interval;
    logic [12:0] r_hold, n_hold;
    logic [15:0] r_pos, n_pos;

    logic        r_out_valid;
    logic [19:0] r_out_data;
    logic [19:0] n_out_data;

    logic        s_accept;
    logic        s_enable;
    logic [1:0]  s_phase;
    logic        s_running;
    logic        s_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_code  <= '0;
            r_first_pos  <= '0;
            r_second_pos <= '0;
            r_on_ticks   <= '0;
            r_off_ticks  <= '0;
            r_hold_ticks <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                atpts_pkg::CFG_TEST_CODE:       r_test_code  <= i_cfg_data[7:0];
                atpts_pkg::CFG_FIRST_POSITION:  r_first_pos  <= atpts_pkg::clamp_pos(i_cfg_data);
                atpts_pkg::CFG_SECOND_POSITION: r_second_pos <= atpts_pkg::clamp_pos(i_cfg_data);
                atpts_pkg::CFG_ON_TICKS:        r_on_ticks   <= atpts_pkg::clamp_time(i_cfg_data);
                atpts_pkg::CFG_OFF_TICKS:       r_off_ticks  <= atpts_pkg::clamp_time(i_cfg_data);
                atpts_pkg::CFG_HOLD_TICKS:      r_hold_ticks <= atpts_pkg::clamp_hold(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign s_enable        = i_s_axis_tdata[0] && (i_s_axis_tdata[8:1] == r_test_code);

    always_comb begin
        n_state    = r_state;
        n_interval = r_interval;
        n_hold     = r_hold;
        n_pos      = r_pos;
        unique case (r_state)
            atpts_pkg::ST_IDLE: begin
                if (s_enable) begin
                    n_state    = atpts_pkg::ST_POS1;
                    n_pos      = r_first_pos;
                    n_interval = r_on_ticks;
                end
            end
            atpts_pkg::ST_POS1: begin
                if (!s_enable) begin
                    n_state = atpts_pkg::ST_IDLE;
                    n_pos   = '0;
                end else if (r_interval <= 12'd1) begin
                    n_state    = atpts_pkg::ST_POS2;
                    n_pos      = r_second_pos;
                    n_interval = r_off_ticks;
                end else begin
                    n_interval = r_interval - 12'd1;
                end
            end
            atpts_pkg::ST_POS2: begin
                if (!s_enable) begin
                    n_state = atpts_pkg::ST_IDLE;
                    n_pos   = '0;
                end else if (r_interval <= 12'd1) begin
                    n_state = atpts_pkg::ST_END;
                    n_pos   = '0;
                    n_hold  = r_hold_ticks;
                end else begin
                    n_interval = r_interval - 12'd1;
                end
            end
            atpts_pkg::ST_END: begin
                // leave only on an enabled tick once the hold has run out
                if (s_enable && (r_hold == '0)) begin
                    n_state = atpts_pkg::ST_IDLE;
                    n_pos   = '0;
                end else if (r_hold != '0) begin
                    n_hold = r_hold - 13'd1;
                end
            end
            default: begin
                n_state = atpts_pkg::ST_IDLE;
                n_pos   = '0;
            end
        endcase
    end

    always_comb begin
        unique case (n_state)
            atpts_pkg::ST_POS1: s_phase = atpts_pkg::PHASE_ONE;
            atpts_pkg::ST_POS2: s_phase = atpts_pkg::PHASE_TWO;
            atpts_pkg::ST_END:  s_phase = atpts_pkg::PHASE_END;
            default:            s_phase = atpts_pkg::PHASE_IDLE;
        endcase
    end

    assign s_running  = (n_state == atpts_pkg::ST_POS1) || (n_state == atpts_pkg::ST_POS2);
    assign s_done     = (n_state == atpts_pkg::ST_END);
    assign n_out_data = {n_pos, s_done, s_running, s_phase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atpts_pkg::ST_IDLE;
            r_interval  <= '0;
            r_hold      <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_state    <= n_state;
                r_interval <= n_interval;
                r_hold     <= n_hold;
                r_pos      <= n_pos;
            end
            // refill on accept, drop once the result transaction completes
            if (s_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_data};

endmodule

// ===== bench/tb_actuator_two_position_test_sequencer_core.sv =====
module tb_actuator_two_position_test_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_TICKS  = 1570;
    localparam int unsigned LONG_TICKS    = 250;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned MAX_REPORTS   = 200;
    localparam logic [2:0]  CFG_SPARE_IDX = 3'd6;

    // {service_enable, action_code} pairs for the directed part
    localparam logic [8:0] SEQ_A [16] = '{
        9'h0FF, 9'h1FE, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h0FF,
        9'h1FF, 9'h1FF, 9'h100, 9'h1FF, 9'h1FF, 9'h1FF, 9'h0FF, 9'h1FF
    };
    localparam logic [8:0] SEQ_B [8] = '{
        9'h100, 9'h100, 9'h100, 9'h100, 9'h000, 9'h000, 9'h000, 9'h100
    };

    typedef struct packed {
        logic [15:0] position;
        logic        complete;
        logic        in_progress;
        logic [1:0]  phase;
    } t_result;

    class TickScoreboard;
        logic [7:0]  code_q;
        logic [15:0] pos1_q, pos2_q, on_q, off_q, hold_cfg_q;
        logic [1:0]  phase_q;
        logic [11:0] interval_q;
        logic [12:0] hold_q;
        logic        run_q, done_q;
        logic [15:0] pos_q;
        t_result     expected_q[$];
        int unsigned errors, ticks, checked, completions, aborts;

        function new();
            code_q = '0; pos1_q = '0; pos2_q = '0; on_q = '0; off_q = '0; hold_cfg_q = '0;
            phase_q = atpts_pkg::PHASE_IDLE; interval_q = '0; hold_q = '0;
            run_q = 1'b0; done_q = 1'b0; pos_q = '0;
            errors = 0; ticks = 0; checked = 0; completions = 0; aborts = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                atpts_pkg::CFG_TEST_CODE:       code_q     = data[7:0];
                atpts_pkg::CFG_FIRST_POSITION:  pos1_q     = data;
                atpts_pkg::CFG_SECOND_POSITION: pos2_q     = data;
                atpts_pkg::CFG_ON_TICKS:        on_q       = data;
                atpts_pkg::CFG_OFF_TICKS:       off_q      = data;
                atpts_pkg::CFG_HOLD_TICKS:      hold_cfg_q = data;
                default: ;
            endcase
        endfunction

        function logic [15:0] cap_position(logic [15:0] v);
            return (v > atpts_pkg::POS_LIMIT) ? atpts_pkg::POS_LIMIT : v;
        endfunction

        function logic [11:0] cap_interval(logic [15:0] v);
            return (v > 16'(atpts_pkg::TIME_LIMIT)) ? atpts_pkg::TIME_LIMIT : v[11:0];
        endfunction

        function logic [12:0] cap_hold(logic [15:0] v);
            return (v > 16'(atpts_pkg::HOLD_LIMIT)) ? atpts_pkg::HOLD_LIMIT : v[12:0];
        endfunction

        function void drop_to_idle();
            phase_q = atpts_pkg::PHASE_IDLE;
            done_q  = 1'b0;
            run_q   = 1'b0;
            pos_q   = '0;
        endfunction

        function void note_tick(logic en_bit, logic [7:0] code);
            logic    active;
            t_result r;
            active = en_bit && (code == code_q);
            ticks++;
            case (phase_q)
                atpts_pkg::PHASE_IDLE: begin
                    if (active) begin
                        phase_q    = atpts_pkg::PHASE_ONE;
                        run_q      = 1'b1;
                        pos_q      = cap_position(pos1_q);
                        interval_q = cap_interval(on_q);
                    end
                end
                atpts_pkg::PHASE_ONE: begin
                    if (!active) begin
                        drop_to_idle();
                        aborts++;
                    end else if (interval_q <= 12'd1) begin
                        phase_q    = atpts_pkg::PHASE_TWO;
                        pos_q      = cap_position(pos2_q);
                        interval_q = cap_interval(off_q);
                    end else begin
                        interval_q = interval_q - 12'd1;
                    end
                end
                atpts_pkg::PHASE_TWO: begin
                    if (!active) begin
                        drop_to_idle();
                        aborts++;
                    end else if (interval_q <= 12'd1) begin
                        phase_q = atpts_pkg::PHASE_END;
                        done_q  = 1'b1;
                        run_q   = 1'b0;
                        pos_q   = '0;
                        hold_q  = cap_hold(hold_cfg_q);
                        completions++;
                    end else begin
                        interval_q = interval_q - 12'd1;
                    end
                end
                default: begin
                    // hold keeps draining even while disabled, stops at zero
                    if (active && hold_q == '0) begin
                        drop_to_idle();
                    end else if (hold_q != '0) begin
                        hold_q = hold_q - 13'd1;
                    end
                end
            endcase
            r.phase       = phase_q;
            r.in_progress = run_q;
            r.complete    = done_q;
            r.position    = pos_q;
            expected_q.push_back(r);
        endfunction

        function void flag(string what, logic [15:0] want, logic [15:0] got);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
            end else if (errors == MAX_REPORTS + 1) begin
                $display("%0t ns: further mismatches not shown", $time);
            end
        endfunction

        function void check_result(logic [23:0] tdata);
            t_result got, want;
            got = t_result'(tdata[19:0]);
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: result %h arrived with no tick outstanding, expected none",
                         $time, tdata);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.phase !== want.phase)
                flag("phase", 16'(want.phase), 16'(got.phase));
            if (got.in_progress !== want.in_progress)
                flag("in_progress", 16'(want.in_progress), 16'(got.in_progress));
            if (got.complete !== want.complete)
                flag("complete", 16'(want.complete), 16'(got.complete));
            if (got.position !== want.position)
                flag("position_request", want.position, got.position);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;
    logic        tick_valid = 1'b0;
    logic        tick_ready;
    logic [15:0] tick_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [23:0] res_data;

    bit          src_gaps = 1'b1;
    bit          sink_gaps = 1'b1;
    int unsigned settings_used = 0;
    int unsigned stall_cycles = 0;

    TickScoreboard sb = new();

    actuator_two_position_test_sequencer_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (tick_valid),
        .o_s_axis_tready (tick_ready),
        .i_s_axis_tdata  (tick_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        res_ready <= sink_gaps ? ($urandom_range(0, 99) >= 30) : 1'b1;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_wr_en)
                sb.write_reg(cfg_idx, cfg_data);
            if (tick_valid && tick_ready)
                sb.note_tick(tick_data[0], tick_data[8:1]);
            if (res_valid && res_ready)
                sb.check_result(res_data);
            if ((tick_valid && tick_ready) || (res_valid && res_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic en, input logic [7:0] code);
        while (src_gaps && $urandom_range(0, 99) < 30) begin
            tick_valid <= 1'b0;
            @(negedge clk);
        end
        tick_valid <= 1'b1;
        tick_data  <= {7'd0, code, en};
        do @(posedge clk); while (!tick_ready);
        @(negedge clk);
    endtask

    // drop valid and wait for every outstanding result, plus the block's latency
    task automatic settle();
        tick_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [7:0] code, input logic [15:0] p1,
                                  input logic [15:0] p2, input logic [15:0] on_t,
                                  input logic [15:0] off_t, input logic [15:0] hold_t);
        cfg_write(atpts_pkg::CFG_TEST_CODE, {8'd0, code});
        cfg_write(atpts_pkg::CFG_FIRST_POSITION, p1);
        cfg_write(atpts_pkg::CFG_SECOND_POSITION, p2);
        cfg_write(atpts_pkg::CFG_ON_TICKS, on_t);
        cfg_write(atpts_pkg::CFG_OFF_TICKS, off_t);
        cfg_write(atpts_pkg::CFG_HOLD_TICKS, hold_t);
        // unmapped index must leave every register alone
        cfg_write(CFG_SPARE_IDX, 16'($urandom));
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_position();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'(32767 + $urandom_range(0, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_duration(input int unsigned top);
        case ($urandom_range(0, 19))
            0, 1:    return 16'd0;
            2, 3:    return 16'd1;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(2, top));
        endcase
    endfunction

    initial begin
        logic [7:0]  code;
        logic [7:0]  any_code;
        int unsigned sent;
        int unsigned group_len;
        int unsigned pick;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero-length and one-tick phases, aborts from both positions, disabled end hold
        apply_settings(8'hFF, 16'd32768, 16'd32769, 16'd0, 16'd1, 16'd0);
        foreach (SEQ_A[k]) send_tick(SEQ_A[k][8], SEQ_A[k][7:0]);
        settle();
        apply_settings(8'h00, 16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd2);
        foreach (SEQ_B[k]) send_tick(SEQ_B[k][8], SEQ_B[k][7:0]);
        settle();

        sent = 0;
        while (sent < RANDOM_TICKS) begin
            // one stretch of back-to-back traffic on both sides
            src_gaps  = !(sent >= 600 && sent < 1000);
            sink_gaps = src_gaps;
            case ($urandom_range(0, 3))
                0:       code = 8'h00;
                1:       code = 8'hFF;
                default: code = 8'($urandom_range(0, 255));
            endcase
            apply_settings(code, pick_position(), pick_position(),
                           pick_duration(10), pick_duration(10), pick_duration(15));
            group_len = $urandom_range(30, 90);
            repeat (group_len) begin
                pick     = $urandom_range(0, 99);
                any_code = 8'($urandom_range(0, 255));
                if (pick < 80)
                    send_tick(1'b1, code);
                else if (pick < 90)
                    send_tick(1'b0, any_code);
                else
                    send_tick(1'b1, any_code);
                sent++;
            end
            settle();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;

        // long enabled run with every position and duration register above its ceiling
        apply_settings(8'h5A, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (LONG_TICKS) send_tick(1'b1, 8'h5A);
        settle();

        repeat (5) @(posedge clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t ns: %0d results never arrived", $time, sb.pending());
        end
        $display("ran %0d ticks and checked %0d results under %0d register settings",
                 sb.ticks, sb.checked, settings_used);
        $display("%0d sequences reached the end phase, %0d were cut short by a disable",
                 sb.completions, sb.aborts);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
